[rtl/core/tsmp_pkg.sv]
package tsmp_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 4096;
  localparam int unsigned VALUE_WIDTH_DEF  = 32;

  localparam int unsigned TOKEN_W  = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned TOPK_W   = 13;
  localparam int unsigned TOPP_W   = 17;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [63:0]       GOLDEN     = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0]       XS_MULT    = 64'h2545_F491_4F6C_DD1D;
  localparam logic [30:0]       Q30_ONE    = 31'h4000_0000;
  localparam logic [16:0]       LOG2E_Q16  = 17'd94548;
  localparam logic [29:0]       LN2_Q30    = 30'd744261118;
  localparam logic [22:0]       CLAMP_Q16  = 23'd5242880;
  localparam logic [31:0]       RECIP3     = 32'hAAAA_AAAB;
  localparam logic [31:0]       RECIP5     = 32'hCCCC_CCCD;
  localparam logic [TOPP_W-1:0] TOPP_RESET = 17'h1_0000;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_MASS  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMPERATURE = 2'd0,
    REG_TOP_K       = 2'd1,
    REG_TOP_P       = 2'd2,
    REG_SEED        = 2'd3
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DECIDE,
    ST_CP_RD, ST_CP_WR,
    ST_SA_RD, ST_SA_M, ST_EXP_DIV, ST_EXP_T, ST_EXP_Y, ST_EXP_P0,
    ST_EXP_YP, ST_EXP_RC, ST_EXP_UPD, ST_EXP_E, ST_W_DIV,
    ST_SO_KEY, ST_SO_KW, ST_SO_CHK, ST_SO_O, ST_SO_CMP,
    ST_TR_RD, ST_TR_O, ST_TR_ACC, ST_TR_CHK,
    ST_DR_M0, ST_DR_M1, ST_DR_M2, ST_DR_M3,
    ST_RS_M0, ST_RS_M1, ST_RS_M2,
    ST_WK_RD, ST_WK_O, ST_WK_ACC, ST_WK_CMP
  } state_t;

  function automatic logic [63:0] xorshift_step(input logic [63:0] s);
    logic [63:0] x;
    x = s;
    x = x ^ (x >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    return x;
  endfunction

endpackage

[rtl/core/tsmp_ram.sv]
module tsmp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/token_sampler_topk_topp.sv]
// Token sampler. Elements are loaded one per cycle (start high while busy is
// low); the element flagged last raises busy and, after the sampling run,
// exactly one result is strobed on out_valid for a single cycle, with busy
// falling in that same cycle. The receiver cannot stall, so capture it then.
// Overflow and greedy (temperature zero) results are emitted from the decide
// state that follows the last element, with no sampling run. With sampling,
// the run is bound by one shared restoring divider and one shared 32x32
// multiplier: softmax takes two exp evaluations and one weight division per
// element, probabilities a copy per element; the in-memory insertion sort
// makes up to n*(n-1)/2 compares, trimming scans the ranked entries, then
// come the draw and the CDF walk over the entries visited. Configuration
// must be written while busy is low; a seed write reloads the generator.
module token_sampler_topk_topp #(
  parameter int unsigned MAX_ELEMENTS = tsmp_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_WIDTH  = tsmp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic signed [31:0]              in_element_value,
  input  logic                            in_last_element,
  output logic                            out_valid,
  output logic [tsmp_pkg::TOKEN_W-1:0]    out_token_index,
  output logic [tsmp_pkg::STATUS_W-1:0]   out_status,
  input  logic                            cfg_we,
  input  logic [tsmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsmp_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int unsigned IW  = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned EW  = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam int unsigned WW  = (VALUE_WIDTH < 18) ? 18 : VALUE_WIDTH;
  localparam int unsigned TW  = 31 + CW;
  localparam int unsigned SW0 = WW + CW;
  localparam int unsigned SW  = (SW0 > 33) ? SW0 : 33;
  localparam int unsigned MB  = (SW - 32 > 32) ? SW - 32 : 32;
  localparam int unsigned PW  = 32 + MB;
  localparam int unsigned DVN = 47;
  localparam int unsigned DVD = TW;
  localparam int unsigned DCW = $clog2(DVN + 1);

  localparam longint SAT_HI_L = (longint'(1) << (EW - 1)) - 1;
  localparam logic signed [31:0] SAT_HI = 32'(SAT_HI_L);
  localparam logic signed [31:0] SAT_LO = 32'(-SAT_HI_L - 1);

  tsmp_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic signed [EW-1:0]       runmax_r, runmax_nxt;
  logic [IW-1:0]              best_r, best_nxt;
  logic                       kind_r, kind_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [tsmp_pkg::TEMP_W-1:0] temp_r, temp_nxt;
  logic [tsmp_pkg::TOPK_W-1:0] topk_r, topk_nxt;
  logic [tsmp_pkg::TOPP_W-1:0] topp_r, topp_nxt;
  logic [63:0]                gen_r, gen_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [tsmp_pkg::TOKEN_W-1:0] out_idx_r, out_idx_nxt;
  tsmp_pkg::status_t          out_status_r, out_status_nxt;

  logic [CW-1:0]              i_r, i_nxt, j_r, j_nxt, keep_r, keep_nxt;
  logic                       pass_b_r, pass_b_nxt;
  logic [TW-1:0]              total_r, total_nxt;
  logic signed [SW-1:0]       acc_r, acc_nxt, sum_r, sum_nxt;
  logic signed [WW-1:0]       kw_r, kw_nxt;
  logic [IW-1:0]              oval_r, oval_nxt;
  logic [29:0]                y_r, y_nxt, x_r, x_nxt;
  logic [30:0]                p_r, p_nxt;
  logic [2:0]                 kk_r, kk_nxt;
  logic [7:0]                 q_r, q_nxt;
  logic [31:0]                hs_r, hs_nxt, rnd_r, rnd_nxt;
  logic [63:0]                plow_r, plow_nxt;
  logic [SW+31:0]             pr_r, pr_nxt;
  logic [PW-1:0]              prod_r, prod_nxt;
  logic [31:0]                mul_a;
  logic [MB-1:0]              mul_b;

  logic [DVD:0]               dv_rem_r, dv_rem_nxt;
  logic [DVN-1:0]             dv_q_r, dv_q_nxt;
  logic [DVD-1:0]             dv_div_r, dv_div_nxt;
  logic [DCW-1:0]             dv_cnt_r, dv_cnt_nxt;
  logic [DVD:0]               rem_sh;
  logic                       rem_ge;

  // memory ports
  logic            v_we, w_we, o_we;
  logic [IW-1:0]   v_wa, v_ra, w_wa, w_ra, o_wa, o_ra;
  logic [VW-1:0]   v_wd, v_rd;
  logic [WW-1:0]   w_wd, w_rd;
  logic [IW-1:0]   o_wd, o_rd;

  // combinational helpers
  logic signed [31:0]   v_sat32;
  logic signed [EW-1:0] v_sat;
  logic signed [EW-1:0] v_lo;
  logic signed [VW-1:0] v_rd_s;
  logic signed [WW-1:0] w_rd_s;
  logic [EW:0]          m_val;
  logic [22:0]          u_val;
  logic [29:0]          dq;
  logic [30:0]          e_val;
  logic [CW-1:0]        i_inc;
  logic                 pmode;
  logic signed [SW-1:0] topp_s;
  logic                 emit;
  logic [tsmp_pkg::TOKEN_W-1:0] emit_idx;
  tsmp_pkg::status_t    emit_status;

  tsmp_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_value_ram (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
  );
  tsmp_ram #(.WIDTH(WW), .DEPTH(MAX_ELEMENTS)) u_weight_ram (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
  );
  tsmp_ram #(.WIDTH(IW), .DEPTH(MAX_ELEMENTS)) u_order_ram (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
  );

  assign busy            = (state_r != tsmp_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_token_index = out_idx_r;
  assign out_status      = out_status_r;

  assign v_sat32 = (in_element_value > SAT_HI) ? SAT_HI :
                   (in_element_value < SAT_LO) ? SAT_LO : in_element_value;
  assign v_sat   = v_sat32[EW-1:0];
  assign v_lo    = v_rd[EW-1:0];
  assign v_rd_s  = v_rd;
  assign w_rd_s  = w_rd;
  assign m_val   = {runmax_r[EW-1], runmax_r} - {v_lo[EW-1], v_lo};
  assign u_val   = (dv_q_r > DVN'(tsmp_pkg::CLAMP_Q16)) ? tsmp_pkg::CLAMP_Q16 : dv_q_r[22:0];
  assign e_val   = (q_r > 8'd30) ? '0 : (p_r >> q_r[4:0]);
  assign i_inc   = i_r + 1'b1;
  assign pmode   = (topp_r != '0) && !topp_r[tsmp_pkg::TOPP_W-1];
  assign topp_s  = SW'(topp_r);

  // one restoring step of the shared divider
  assign rem_sh  = {dv_rem_r[DVD-1:0], dv_q_r[DVN-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dv_div_r});

  // reciprocal or shift, depending on the series term
  always_comb begin
    unique case (kk_r)
      3'd5:    dq = prod_r[63:34];
      3'd4:    dq = x_r >> 2;
      3'd3:    dq = prod_r[62:33];
      3'd2:    dq = x_r >> 1;
      default: dq = x_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsmp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      runmax_r     <= '0;
      best_r       <= '0;
      kind_r       <= 1'b0;
      ovf_r        <= 1'b0;
      temp_r       <= '0;
      topk_r       <= '0;
      topp_r       <= tsmp_pkg::TOPP_RESET;
      gen_r        <= tsmp_pkg::GOLDEN;
      out_valid_r  <= 1'b0;
      dv_cnt_r     <= '0;
    end else begin
      cnt_r        <= cnt_nxt;
      runmax_r     <= runmax_nxt;
      best_r       <= best_nxt;
      kind_r       <= kind_nxt;
      ovf_r        <= ovf_nxt;
      temp_r       <= temp_nxt;
      topk_r       <= topk_nxt;
      topp_r       <= topp_nxt;
      gen_r        <= gen_nxt;
      out_valid_r  <= out_valid_nxt;
      dv_cnt_r     <= dv_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    keep_r   <= keep_nxt;
    pass_b_r <= pass_b_nxt;
    total_r  <= total_nxt;
    acc_r    <= acc_nxt;
    sum_r    <= sum_nxt;
    kw_r     <= kw_nxt;
    oval_r   <= oval_nxt;
    y_r      <= y_nxt;
    x_r      <= x_nxt;
    p_r      <= p_nxt;
    kk_r     <= kk_nxt;
    q_r      <= q_nxt;
    hs_r     <= hs_nxt;
    rnd_r    <= rnd_nxt;
    plow_r   <= plow_nxt;
    pr_r     <= pr_nxt;
    prod_r   <= prod_nxt;
    dv_rem_r <= dv_rem_nxt;
    dv_q_r   <= dv_q_nxt;
    dv_div_r <= dv_div_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    runmax_nxt     = runmax_r;
    best_nxt       = best_r;
    kind_nxt       = kind_r;
    ovf_nxt        = ovf_r;
    temp_nxt       = temp_r;
    topk_nxt       = topk_r;
    topp_nxt       = topp_r;
    gen_nxt        = gen_r;
    out_valid_nxt  = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    keep_nxt   = keep_r;
    pass_b_nxt = pass_b_r;
    total_nxt  = total_r;
    acc_nxt    = acc_r;
    sum_nxt    = sum_r;
    kw_nxt     = kw_r;
    oval_nxt   = oval_r;
    y_nxt      = y_r;
    x_nxt      = x_r;
    p_nxt      = p_r;
    kk_nxt     = kk_r;
    q_nxt      = q_r;
    hs_nxt     = hs_r;
    rnd_nxt    = rnd_r;
    plow_nxt   = plow_r;
    pr_nxt     = pr_r;
    mul_a      = '0;
    mul_b      = '0;
    dv_rem_nxt = dv_rem_r;
    dv_q_nxt   = dv_q_r;
    dv_div_nxt = dv_div_r;
    dv_cnt_nxt = dv_cnt_r;
    v_we = 1'b0; v_wa = '0; v_wd = '0; v_ra = '0;
    w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
    emit        = 1'b0;
    emit_idx    = '0;
    emit_status = tsmp_pkg::STATUS_OK;

    if (cfg_we) begin
      unique case (tsmp_pkg::cfg_reg_t'(cfg_index))
        tsmp_pkg::REG_TEMPERATURE: temp_nxt = cfg_wdata[tsmp_pkg::TEMP_W-1:0];
        tsmp_pkg::REG_TOP_K:       topk_nxt = cfg_wdata[tsmp_pkg::TOPK_W-1:0];
        tsmp_pkg::REG_TOP_P:       topp_nxt = cfg_wdata[tsmp_pkg::TOPP_W-1:0];
        tsmp_pkg::REG_SEED:
          gen_nxt = (cfg_wdata != '0) ? cfg_wdata : tsmp_pkg::GOLDEN;
      endcase
    end

    if (dv_cnt_r != '0) begin
      dv_rem_nxt = rem_ge ? (rem_sh - {1'b0, dv_div_r}) : rem_sh;
      dv_q_nxt   = {dv_q_r[DVN-2:0], rem_ge};
      dv_cnt_nxt = dv_cnt_r - 1'b1;
    end

    unique case (state_r)
      tsmp_pkg::ST_IDLE: begin
        if (start) begin
          if (cnt_r == '0 && !ovf_r) begin
            kind_nxt = in_func;
          end
          if (cnt_r < CW'(MAX_ELEMENTS)) begin
            v_we = 1'b1;
            v_wa = cnt_r[IW-1:0];
            v_wd = VW'(v_sat);
            if (cnt_r == '0 || v_sat > runmax_r) begin
              runmax_nxt = v_sat;
              best_nxt   = cnt_r[IW-1:0];
            end
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_element) begin
            state_nxt = tsmp_pkg::ST_DECIDE;
          end
        end
      end

      tsmp_pkg::ST_DECIDE: begin
        i_nxt = '0;
        if (ovf_r) begin
          emit        = 1'b1;
          emit_status = tsmp_pkg::STATUS_OVERFLOW;
        end else if (temp_r == '0) begin
          emit     = 1'b1;
          emit_idx = tsmp_pkg::TOKEN_W'(best_r);
        end else if (!kind_r) begin
          pass_b_nxt = 1'b0;
          total_nxt  = '0;
          state_nxt  = tsmp_pkg::ST_SA_RD;
        end else begin
          state_nxt = tsmp_pkg::ST_CP_RD;
        end
      end

      // probabilities are taken as weights unchanged
      tsmp_pkg::ST_CP_RD: begin
        v_ra      = i_r[IW-1:0];
        state_nxt = tsmp_pkg::ST_CP_WR;
      end

      tsmp_pkg::ST_CP_WR: begin
        w_we = 1'b1;
        w_wa = i_r[IW-1:0];
        w_wd = WW'(v_rd_s);
        if (i_inc == cnt_r) begin
          i_nxt     = '0;
          state_nxt = tsmp_pkg::ST_SO_KEY;
        end else begin
          i_nxt     = i_inc;
          state_nxt = tsmp_pkg::ST_CP_RD;
        end
      end

      // softmax: pass a sums exp terms, pass b recomputes and normalises
      tsmp_pkg::ST_SA_RD: begin
        v_ra      = i_r[IW-1:0];
        state_nxt = tsmp_pkg::ST_SA_M;
      end

      tsmp_pkg::ST_SA_M: begin
        dv_rem_nxt = '0;
        dv_q_nxt   = DVN'({m_val, 8'd0});
        dv_div_nxt = DVD'(temp_r);
        dv_cnt_nxt = DCW'(DVN);
        state_nxt  = tsmp_pkg::ST_EXP_DIV;
      end

      tsmp_pkg::ST_EXP_DIV: begin
        if (dv_cnt_r == '0) begin
          state_nxt = tsmp_pkg::ST_EXP_T;
        end
      end

      tsmp_pkg::ST_EXP_T: begin
        mul_a     = 32'(u_val);
        mul_b     = MB'(tsmp_pkg::LOG2E_Q16);
        state_nxt = tsmp_pkg::ST_EXP_Y;
      end

      tsmp_pkg::ST_EXP_Y: begin
        q_nxt     = prod_r[39:32];
        mul_a     = 32'(prod_r[31:16]);
        mul_b     = MB'(tsmp_pkg::LN2_Q30);
        state_nxt = tsmp_pkg::ST_EXP_P0;
      end

      tsmp_pkg::ST_EXP_P0: begin
        y_nxt     = prod_r[45:16];
        p_nxt     = tsmp_pkg::Q30_ONE;
        kk_nxt    = 3'd5;
        state_nxt = tsmp_pkg::ST_EXP_YP;
      end

      tsmp_pkg::ST_EXP_YP: begin
        mul_a     = 32'(y_r);
        mul_b     = MB'(p_r);
        state_nxt = tsmp_pkg::ST_EXP_RC;
      end

      tsmp_pkg::ST_EXP_RC: begin
        x_nxt     = prod_r[59:30];
        mul_a     = 32'(prod_r[59:30]);
        mul_b     = (kk_r == 3'd5) ? MB'(tsmp_pkg::RECIP5) : MB'(tsmp_pkg::RECIP3);
        state_nxt = tsmp_pkg::ST_EXP_UPD;
      end

      tsmp_pkg::ST_EXP_UPD: begin
        p_nxt  = tsmp_pkg::Q30_ONE - {1'b0, dq};
        kk_nxt = kk_r - 1'b1;
        if (kk_r == 3'd1) begin
          state_nxt = tsmp_pkg::ST_EXP_E;
        end else begin
          state_nxt = tsmp_pkg::ST_EXP_YP;
        end
      end

      tsmp_pkg::ST_EXP_E: begin
        if (!pass_b_r) begin
          total_nxt = total_r + TW'(e_val);
          if (i_inc == cnt_r) begin
            i_nxt      = '0;
            pass_b_nxt = 1'b1;
          end else begin
            i_nxt = i_inc;
          end
          state_nxt = tsmp_pkg::ST_SA_RD;
        end else begin
          dv_rem_nxt = '0;
          dv_q_nxt   = {e_val, 16'd0};
          dv_div_nxt = (total_r == '0) ? DVD'(1) : total_r;
          dv_cnt_nxt = DCW'(DVN);
          state_nxt  = tsmp_pkg::ST_W_DIV;
        end
      end

      tsmp_pkg::ST_W_DIV: begin
        if (dv_cnt_r == '0) begin
          w_we = 1'b1;
          w_wa = i_r[IW-1:0];
          w_wd = WW'(dv_q_r);
          if (i_inc == cnt_r) begin
            i_nxt     = '0;
            state_nxt = tsmp_pkg::ST_SO_KEY;
          end else begin
            i_nxt     = i_inc;
            state_nxt = tsmp_pkg::ST_SA_RD;
          end
        end
      end

      // insertion sort of indices, heavier first, equal weights keep order
      tsmp_pkg::ST_SO_KEY: begin
        w_ra      = i_r[IW-1:0];
        state_nxt = tsmp_pkg::ST_SO_KW;
      end

      tsmp_pkg::ST_SO_KW: begin
        kw_nxt    = w_rd_s;
        j_nxt     = i_r;
        state_nxt = tsmp_pkg::ST_SO_CHK;
      end

      tsmp_pkg::ST_SO_CHK: begin
        if (j_r == '0) begin
          o_we = 1'b1;
          o_wa = '0;
          o_wd = i_r[IW-1:0];
          if (i_inc == cnt_r) begin
            keep_nxt  = (topk_r != '0 && topk_r < cnt_r) ? CW'(topk_r) : cnt_r;
            i_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = tsmp_pkg::ST_TR_RD;
          end else begin
            i_nxt     = i_inc;
            state_nxt = tsmp_pkg::ST_SO_KEY;
          end
        end else begin
          o_ra      = IW'(j_r - 1'b1);
          state_nxt = tsmp_pkg::ST_SO_O;
        end
      end

      tsmp_pkg::ST_SO_O: begin
        oval_nxt  = o_rd;
        w_ra      = o_rd;
        state_nxt = tsmp_pkg::ST_SO_CMP;
      end

      tsmp_pkg::ST_SO_CMP: begin
        o_we = 1'b1;
        o_wa = j_r[IW-1:0];
        if (w_rd_s < kw_r) begin
          o_wd      = oval_r;
          j_nxt     = j_r - 1'b1;
          state_nxt = tsmp_pkg::ST_SO_CHK;
        end else begin
          o_wd = i_r[IW-1:0];
          if (i_inc == cnt_r) begin
            keep_nxt  = (topk_r != '0 && topk_r < cnt_r) ? CW'(topk_r) : cnt_r;
            i_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = tsmp_pkg::ST_TR_RD;
          end else begin
            i_nxt     = i_inc;
            state_nxt = tsmp_pkg::ST_SO_KEY;
          end
        end
      end

      // top-k and top-p scan, which also yields the kept sum
      tsmp_pkg::ST_TR_RD: begin
        o_ra      = i_r[IW-1:0];
        state_nxt = tsmp_pkg::ST_TR_O;
      end

      tsmp_pkg::ST_TR_O: begin
        w_ra      = o_rd;
        state_nxt = tsmp_pkg::ST_TR_ACC;
      end

      tsmp_pkg::ST_TR_ACC: begin
        acc_nxt   = acc_r + SW'(w_rd_s);
        i_nxt     = i_inc;
        state_nxt = tsmp_pkg::ST_TR_CHK;
      end

      tsmp_pkg::ST_TR_CHK: begin
        if (i_r == keep_r || (pmode && acc_r >= topp_s)) begin
          keep_nxt = i_r;
          sum_nxt  = acc_r;
          if (acc_r[SW-1] || acc_r == '0) begin
            emit        = 1'b1;
            emit_status = tsmp_pkg::STATUS_NO_MASS;
          end else begin
            gen_nxt   = tsmp_pkg::xorshift_step(gen_r);
            state_nxt = tsmp_pkg::ST_DR_M0;
          end
        end else begin
          state_nxt = tsmp_pkg::ST_TR_RD;
        end
      end

      // upper half of the low 64 bits of state times multiplier
      tsmp_pkg::ST_DR_M0: begin
        mul_a     = gen_r[31:0];
        mul_b     = MB'(tsmp_pkg::XS_MULT[31:0]);
        state_nxt = tsmp_pkg::ST_DR_M1;
      end

      tsmp_pkg::ST_DR_M1: begin
        hs_nxt    = prod_r[63:32];
        mul_a     = gen_r[31:0];
        mul_b     = MB'(tsmp_pkg::XS_MULT[63:32]);
        state_nxt = tsmp_pkg::ST_DR_M2;
      end

      tsmp_pkg::ST_DR_M2: begin
        hs_nxt    = hs_r + prod_r[31:0];
        mul_a     = gen_r[63:32];
        mul_b     = MB'(tsmp_pkg::XS_MULT[31:0]);
        state_nxt = tsmp_pkg::ST_DR_M3;
      end

      tsmp_pkg::ST_DR_M3: begin
        rnd_nxt   = hs_r + prod_r[31:0];
        state_nxt = tsmp_pkg::ST_RS_M0;
      end

      // draw times kept sum, exact
      tsmp_pkg::ST_RS_M0: begin
        mul_a     = rnd_r;
        mul_b     = MB'(sum_r[31:0]);
        state_nxt = tsmp_pkg::ST_RS_M1;
      end

      tsmp_pkg::ST_RS_M1: begin
        plow_nxt  = prod_r[63:0];
        mul_a     = rnd_r;
        mul_b     = MB'(sum_r[SW-1:32]);
        state_nxt = tsmp_pkg::ST_RS_M2;
      end

      tsmp_pkg::ST_RS_M2: begin
        pr_nxt    = {prod_r[SW-1:0], 32'd0} + (SW+32)'(plow_r);
        i_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = tsmp_pkg::ST_WK_RD;
      end

      // cdf walk
      tsmp_pkg::ST_WK_RD: begin
        o_ra      = i_r[IW-1:0];
        state_nxt = tsmp_pkg::ST_WK_O;
      end

      tsmp_pkg::ST_WK_O: begin
        oval_nxt  = o_rd;
        w_ra      = o_rd;
        state_nxt = tsmp_pkg::ST_WK_ACC;
      end

      tsmp_pkg::ST_WK_ACC: begin
        acc_nxt   = acc_r + SW'(w_rd_s);
        state_nxt = tsmp_pkg::ST_WK_CMP;
      end

      tsmp_pkg::ST_WK_CMP: begin
        if ((!acc_r[SW-1] && pr_r <= {acc_r, 32'd0}) || i_inc == keep_r) begin
          emit     = 1'b1;
          emit_idx = tsmp_pkg::TOKEN_W'(oval_r);
        end else begin
          i_nxt     = i_inc;
          state_nxt = tsmp_pkg::ST_WK_RD;
        end
      end

      default: begin
        state_nxt = tsmp_pkg::ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_idx_nxt    = emit_idx;
      out_status_nxt = emit_status;
      cnt_nxt        = '0;
      runmax_nxt     = '0;
      best_nxt       = '0;
      kind_nxt       = 1'b0;
      ovf_nxt        = 1'b0;
      state_nxt      = tsmp_pkg::ST_IDLE;
    end

    prod_nxt = PW'(mul_a) * PW'(mul_b);
  end

endmodule

[rtl/core/tsmp_checker.sv]
module tsmp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           in_last_element,
  input logic                           out_valid,
  input logic [tsmp_pkg::TOKEN_W-1:0]   out_token_index,
  input logic [tsmp_pkg::STATUS_W-1:0]  out_status
);

  // a vector closed by a last element keeps the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_element |=> busy)
    else $error("busy not raised after last element");

  // busy falls only in the cycle that carries the result
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while still busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tsmp_pkg::STATUS_OVERFLOW ||
                  out_status == tsmp_pkg::STATUS_NO_MASS) |-> out_token_index == '0)
    else $error("error result with nonzero index");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

endmodule

bind token_sampler_topk_topp tsmp_checker u_tsmp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_last_element(in_last_element),
  .out_valid(out_valid),
  .out_token_index(out_token_index),
  .out_status(out_status)
);

[sim/testbench.sv]
module testbench;
  import tsmp_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_ELEMENTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [TOKEN_W-1:0] token;
    status_t            status;
  } pick_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic                   in_func;
  logic signed [31:0]     in_element_value;
  logic                   in_last_element;
  logic                   out_valid;
  logic [TOKEN_W-1:0]     out_token_index;
  logic [STATUS_W-1:0]    out_status;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  token_sampler_topk_topp DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_element_value (in_element_value),
    .in_last_element  (in_last_element),
    .out_valid        (out_valid),
    .out_token_index  (out_token_index),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // sampler state as the block should hold it
  logic [TEMP_W-1:0]  temp_q8 = '0;
  logic [TOPK_W-1:0]  top_k = '0;
  logic [TOPP_W-1:0]  top_p = TOPP_RESET;
  logic [63:0]        gen_state = GOLDEN;
  longint             elem_vals [STORE_DEPTH];
  longint             weights [STORE_DEPTH];
  int unsigned        ranked [STORE_DEPTH];
  int unsigned        elem_count = 0;
  longint             run_max = 0;
  int unsigned        best_at = 0;
  bit                 prob_kind = 0;
  bit                 too_long = 0;

  pick_t       pending_picks [$];
  int unsigned mismatches = 0;
  int unsigned picks_seen = 0;
  int unsigned elems_sent = 0;
  int unsigned cycle_count = 0;
  bit          idling = 1;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] exp_weight(logic [63:0] m);
    logic [63:0] u, t, q, y, p;
    u = (m << 8) / temp_q8;
    if (u > CLAMP_Q16) u = CLAMP_Q16;
    t = (u * LOG2E_Q16) >> 16;
    q = t >> 16;
    y = ((t & 64'hFFFF) * LN2_Q30) >> 16;
    p = 64'd1 << 30;
    for (int k = 5; k >= 1; k--) p = (64'd1 << 30) - ((y * p) >> 30) / k;
    return (q > 30) ? 64'd0 : (p >> q);
  endfunction

  // exact r/2^32 <= c/s
  function automatic bit cdf_reaches(logic [63:0] r, logic [63:0] s, longint c);
    logic [63:0] a, h, cu;
    if (c < 0) return 0;
    cu = c;
    a = r * (s & 64'hFFFF_FFFF);
    h = r * (s >> 32) + (a >> 32);
    return (h < cu) || (h == cu && a[31:0] == 0);
  endfunction

  task automatic pick_token(output pick_t res);
    int unsigned n, keep, i, j, kk;
    longint      sum, acc;
    logic [63:0] total, e, x, r;
    bit          found;
    res.token = '0;
    res.status = STATUS_OK;
    n = elem_count;
    if (too_long) begin
      res.status = STATUS_OVERFLOW;
    end else if (n != 0 && temp_q8 == 0) begin
      res.token = best_at;
    end else if (n != 0) begin
      if (!prob_kind) begin
        total = 0;
        for (i = 0; i < n; i++) begin
          e = exp_weight(64'(run_max - elem_vals[i]));
          weights[i] = e;
          total += e;
        end
        if (total == 0) total = 1;
        for (i = 0; i < n; i++) begin
          e = weights[i];
          weights[i] = (e << 16) / total;
        end
      end else begin
        for (i = 0; i < n; i++) weights[i] = elem_vals[i];
      end
      // descending, equal weights keep lower index first
      for (i = 0; i < n; i++) begin
        j = i;
        while (j > 0 && weights[ranked[j-1]] < weights[i]) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = i;
      end
      keep = n;
      if (top_k > 0 && top_k < keep) keep = top_k;
      if (top_p < TOPP_RESET) begin
        kk = 0;
        acc = 0;
        while (kk < keep && acc < longint'(top_p)) begin
          acc += weights[ranked[kk]];
          kk++;
        end
        if (kk > 0) keep = kk;
      end
      sum = 0;
      for (i = 0; i < keep; i++) sum += weights[ranked[i]];
      if (sum <= 0) begin
        res.status = STATUS_NO_MASS;
      end else begin
        x = gen_state;
        x = x ^ (x >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        gen_state = x;
        r = (x * XS_MULT) >> 32;
        acc = 0;
        found = 0;
        for (i = 0; i < keep; i++) begin
          acc += weights[ranked[i]];
          if (!found && cdf_reaches(r, sum, acc)) begin
            res.token = ranked[i];
            found = 1;
          end
        end
        if (!found) res.token = ranked[keep-1];
      end
    end
  endtask

  task automatic take_element(bit f, logic signed [31:0] v, bit last);
    longint sv;
    pick_t  res;
    sv = v;
    if (elem_count == 0 && !too_long) prob_kind = f;
    if (elem_count < STORE_DEPTH) begin
      elem_vals[elem_count] = sv;
      if (elem_count == 0 || sv > run_max) begin
        run_max = sv;
        best_at = elem_count;
      end
      elem_count++;
    end else begin
      too_long = 1;
    end
    if (last) begin
      pick_token(res);
      pending_picks.push_back(res);
      elem_count = 0;
      run_max = 0;
      best_at = 0;
      prob_kind = 0;
      too_long = 0;
    end
  endtask

  task automatic pause(int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_element(bit f, logic signed [31:0] v, bit last);
    if (idling && $urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
    @(negedge clk);
    start <= 1'b1;
    in_func <= f;
    in_element_value <= v;
    in_last_element <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    take_element(f, v, last);
    elems_sent++;
  endtask

  // block idle: every pick back and no sampling run left
  task automatic settle();
    pause(1);
    while (pending_picks.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [63:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_TEMPERATURE: temp_q8 = d[TEMP_W-1:0];
      REG_TOP_K:       top_k = d[TOPK_W-1:0];
      REG_TOP_P:       top_p = d[TOPP_W-1:0];
      REG_SEED:        gen_state = (d != 0) ? d : GOLDEN;
      default: ;
    endcase
  endtask

  task automatic send_vector(bit f, logic signed [31:0] vals [$]);
    foreach (vals[i]) send_element(f, vals[i], i == vals.size() - 1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_picks.size() == 0) begin
        $display("%0t unexpected pick token %0d status %0d", $time, out_token_index,
                 out_status);
        mismatches++;
      end else begin
        pick_t want;
        want = pending_picks.pop_front();
        picks_seen++;
        if (out_token_index !== want.token) begin
          $display("%0t token mismatch: expected %0d actual %0d", $time, want.token,
                   out_token_index);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, want.status,
                   out_status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_greedy();
    send_vector(0, '{32'sd5, -32'sd3, 32'sd5});
    send_vector(1, '{32'sh8000_0000, 32'sh7FFF_FFFF});
    send_vector(1, '{-32'sd7});
    send_vector(0, '{32'sd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
  endtask

  task automatic test_softmax();
    settle();
    write_reg(REG_TEMPERATURE, 64'd256);
    write_reg(REG_SEED, 64'd0);
    send_vector(0, '{32'sd0, 32'sh1_0000, 32'sh2_0000, 32'sh1_0000});
    send_vector(0, '{32'sh7FFF_FFFF, 32'sh8000_0000});
    settle();
    write_reg(REG_TEMPERATURE, 64'd1);
    send_vector(0, '{32'sh100, 32'sh0, 32'sh180});
    settle();
    write_reg(REG_TEMPERATURE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_vector(0, '{-32'sh50_0000, 32'sh50_0000, 32'sd0});
  endtask

  task automatic test_probabilities();
    send_vector(1, '{32'sd0, 32'sd0, 32'sd0});
    send_vector(1, '{-32'sd5, 32'sd3});
    send_vector(1, '{32'sh4000, 32'shC000, 32'sh4000});
  endtask

  task automatic test_trimming();
    settle();
    write_reg(REG_TOP_K, 64'hFFFF_0000_0000_0002);
    write_reg(REG_TOP_P, 64'd32768);
    write_reg(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_vector(1, '{32'sh1000, 32'sh8000, 32'sh6000, 32'sh2000});
    settle();
    write_reg(REG_TOP_K, 64'd4096);
    write_reg(REG_TOP_P, 64'd0);
    send_vector(0, '{32'sh3_0000, 32'sh3_0000, -32'sh1_0000});
    settle();
    write_reg(REG_TOP_K, 64'd1);
    write_reg(REG_TOP_P, 64'h1_FFFF);
    send_vector(1, '{32'sh100, 32'sh900, 32'sh900});
    settle();
    write_reg(REG_TOP_K, 64'd0);
    write_reg(REG_TOP_P, 64'd65536);
  endtask

  // full store under greedy, then two elements past the store while sampling
  task automatic test_long_vectors();
    settle();
    write_reg(REG_TEMPERATURE, 64'd0);
    for (int i = 0; i < STORE_DEPTH; i++) send_element(0, i, i == STORE_DEPTH - 1);
    settle();
    write_reg(REG_TEMPERATURE, 64'd256);
    for (int i = 0; i < STORE_DEPTH + 2; i++)
      send_element(i[0], $urandom, i == STORE_DEPTH + 1);
  endtask

  function automatic logic signed [31:0] random_value(logic signed [31:0] prev);
    case ($urandom_range(0, 7))
      0, 1, 2: return $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000;
      3:       return $urandom;
      4:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      5:       return prev;
      6:       return $urandom_range(0, 65536);
      default: return 0;
    endcase
  endfunction

  task automatic test_random();
    int unsigned        len, sent;
    bit                 f;
    logic signed [31:0] v;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      idling = (phase < 7);
      case ($urandom_range(0, 4))
        0: write_reg(REG_TEMPERATURE, 64'd0);
        1: write_reg(REG_TEMPERATURE, 64'd1);
        2: write_reg(REG_TEMPERATURE, 64'hFFFF);
        default: write_reg(REG_TEMPERATURE, {$urandom, $urandom_range(1, 1024)});
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_TOP_K, 64'd0);
        1: write_reg(REG_TOP_K, 64'd4096);
        default: write_reg(REG_TOP_K, {$urandom, 32'($urandom_range(0, 8))});
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_TOP_P, 64'd65536);
        1: write_reg(REG_TOP_P, 64'd0);
        default: write_reg(REG_TOP_P, {$urandom, $urandom});
      endcase
      if ($urandom_range(0, 1)) write_reg(REG_SEED, {$urandom, $urandom});
      sent = 0;
      while (sent < 62) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        f = $urandom_range(0, 1);
        v = 0;
        for (int i = 0; i < len; i++) begin
          v = random_value(v);
          // func on later elements must be ignored
          send_element(i == 0 ? f : $urandom_range(0, 1), v, i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = 1'b0;
    in_element_value = '0;
    in_last_element = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TEMPERATURE;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_greedy();
    test_softmax();
    test_probabilities();
    test_trimming();
    test_long_vectors();
    test_random();
    idling = 0;
    pause(1);
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("run covered greedy, softmax and probability sampling with top-k/top-p trimming,");
    $display("overflow and zero mass: %0d elements, %0d picks checked, %0d mismatches",
             elems_sent, picks_seen, mismatches);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
